[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Implication and next-cycle checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[rtl/hrwa_pkg.sv]
// ---------------------------------------------------------------------------
// hrwa_pkg
// Shared widths, constants, register indexes and types of the rate averager.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrwa_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam int TIME_W     = 32;
    localparam int RATE_W     = 12;
    localparam int WIN_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // 60 s/min * 1000 ms/s * 16 (Q8.4)
    localparam int RATE_SCALE = 960000;
    localparam int RATE_NUM_W = 20;

    localparam logic [WIN_W-1:0]  WINDOW_RST   = 16'd10000;
    localparam logic [RATE_W-1:0] MIN_RATE_RST = 12'd480;
    localparam logic [RATE_W-1:0] MAX_RATE_RST = 12'd3520;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [RATE_W-1:0] rate;
    } ring_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_WALK_START,
        S_WALK,
        S_AVG,
        S_AVG_WAIT,
        S_FINISH
    } hrwa_state_t;

endpackage

`default_nettype wire

[rtl/hrwa_ram.sv]
// ---------------------------------------------------------------------------
// hrwa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/hrwa_div.sv]
// ---------------------------------------------------------------------------
// hrwa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrwa_div
    import hrwa_pkg::*;
#(
    parameter int DIVIDEND_W = RATE_NUM_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [TIME_W-1:0]     divisor,
    output      logic                  done,
    output      logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [TIME_W-1:0]     dvs_reg, dvs_next;

    logic [TIME_W:0] shifted;
    logic [TIME_W:0] diff;
    logic            fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/heart_rate_window_average_unit.sv]
// ---------------------------------------------------------------------------
// heart_rate_window_average_unit
// Beat-rate tracker with a time-windowed average over a ring of past rates.
// ---------------------------------------------------------------------------
// One beat in, one result out. A beat (tuser = 1) turns the interval since the
// previous beat into a Q8.4 rate of 960000 / interval, stores it with its time
// when it lies in the configured band, then every item returns the last rate
// and the truncated mean of the stored rates no older than window_ms. The
// block takes one item at a time. A beat with a usable interval first runs
// the rate division; the walk then reads the ring from the newest entry (the
// entries inside the window plus the first older one, at most RING_DEPTH),
// and the mean over a nonempty walk is taken on the same divider. The time an
// item takes is set by the shared one-bit-per-cycle divider and the single
// read port of the ring memory. The result sits in an output register, so
// the next item is taken while it waits; if it still waits when the next
// result is ready, the block holds until m_tready takes it. Configuration
// writes are taken at any time but should only be made when idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module heart_rate_window_average_unit
    import hrwa_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [31:0]           s_tdata,   // [31:0] time_ms
    input  wire logic [0:0]            s_tuser,   // [0] cmd
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [23:0]           m_tdata,   // [11:0] last_rate_q4, [23:12] avg_rate_q4
    output      logic [0:0]            m_tuser    // [0] beat_stored
);

    localparam int ADDR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W   = RATE_W + FILL_W;
    localparam int DIV_W   = (SUM_W > RATE_NUM_W) ? SUM_W : RATE_NUM_W;
    localparam int ENTRY_W = $bits(ring_entry_t);

    hrwa_state_t state_reg, state_next;

    logic [WIN_W-1:0]  window_reg;
    logic [RATE_W-1:0] min_rate_reg;
    logic [RATE_W-1:0] max_rate_reg;

    logic [TIME_W-1:0] time_reg, time_next;
    logic [TIME_W-1:0] cutoff_reg, cutoff_next;
    logic [TIME_W-1:0] prev_beat_reg, prev_beat_next;
    logic [RATE_W-1:0] last_rate_reg, last_rate_next;
    logic [ADDR_W-1:0] write_pos_reg, write_pos_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [FILL_W-1:0] cnt_reg, cnt_next;
    logic              stored_reg, stored_next;
    logic [RATE_W-1:0] avg_reg, avg_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [23:0]       m_tdata_reg, m_tdata_next;
    logic [0:0]        m_tuser_reg, m_tuser_next;

    logic              in_accept;
    logic [TIME_W-1:0] delta;
    logic              beat_go;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [TIME_W-1:0] div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;
    logic              in_band;
    logic              push;
    logic              out_free;
    logic              hit;

    logic [ADDR_W-1:0]  wpos_dec;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ADDR_W-1:0]  raddr_dec;
    logic [ENTRY_W-1:0] ram_rdata;
    ring_entry_t        rd_entry;
    ring_entry_t        wr_entry;

    assign in_accept = s_tvalid && s_tready;
    assign delta     = s_tdata - prev_beat_reg;
    assign beat_go   = s_tuser[0] && (prev_beat_reg != '0) && (delta != '0);
    assign in_band   = (div_q >= DIV_W'(min_rate_reg)) && (div_q <= DIV_W'(max_rate_reg));
    assign push      = (state_reg == S_RATE) && div_done && in_band;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign wpos_dec  = (write_pos_reg == '0) ? ADDR_W'(RING_DEPTH - 1)
                                             : write_pos_reg - ADDR_W'(1);
    assign ram_raddr = (state_reg == S_WALK) ? rd_idx_reg : wpos_dec;
    assign raddr_dec = (ram_raddr == '0) ? ADDR_W'(RING_DEPTH - 1)
                                         : ram_raddr - ADDR_W'(1);
    assign rd_entry  = ring_entry_t'(ram_rdata);
    assign hit       = rd_entry.stamp >= cutoff_reg;

    assign wr_entry.stamp = time_reg;
    assign wr_entry.rate  = div_q[RATE_W-1:0];

    // shared divider: rate at beat time, mean at the end of the walk
    assign div_start    = (in_accept && beat_go) || ((state_reg == S_AVG) && (cnt_reg != '0));
    assign div_dividend = (state_reg == S_IDLE) ? DIV_W'(RATE_SCALE) : DIV_W'(sum_reg);
    assign div_divisor  = (state_reg == S_IDLE) ? delta : TIME_W'(cnt_reg);

    hrwa_div #(
        .DIVIDEND_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    hrwa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (push),
        .waddr (write_pos_reg),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = beat_go ? S_RATE : S_WALK_START;
                end
            end
            S_RATE:
            begin
                if (div_done)
                begin
                    state_next = S_WALK_START;
                end
            end
            S_WALK_START:
            begin
                state_next = (fill_reg == '0) ? S_AVG : S_WALK;
            end
            S_WALK:
            begin
                if (!hit || ((cnt_reg + FILL_W'(1)) == fill_reg))
                begin
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                state_next = (cnt_reg == '0) ? S_FINISH : S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        time_next      = time_reg;
        cutoff_next    = cutoff_reg;
        prev_beat_next = prev_beat_reg;
        last_rate_next = last_rate_reg;
        write_pos_next = write_pos_reg;
        fill_next      = fill_reg;
        rd_idx_next    = rd_idx_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        stored_next    = stored_reg;
        avg_next       = avg_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        s_tready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (in_accept)
                begin
                    time_next   = s_tdata;
                    cutoff_next = (s_tdata > TIME_W'(window_reg))
                                ? s_tdata - TIME_W'(window_reg) : '0;
                    stored_next = 1'b0;
                    if (s_tuser[0])
                    begin
                        prev_beat_next = s_tdata;
                    end
                end
            end
            S_RATE:
            begin
                if (push)
                begin
                    last_rate_next = div_q[RATE_W-1:0];
                    stored_next    = 1'b1;
                    write_pos_next = (write_pos_reg == ADDR_W'(RING_DEPTH - 1))
                                   ? '0 : write_pos_reg + ADDR_W'(1);
                    if (fill_reg != FILL_W'(RING_DEPTH))
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            S_WALK_START:
            begin
                sum_next    = '0;
                cnt_next    = '0;
                rd_idx_next = raddr_dec;
            end
            S_WALK:
            begin
                rd_idx_next = raddr_dec;
                if (hit)
                begin
                    sum_next = sum_reg + SUM_W'(rd_entry.rate);
                    cnt_next = cnt_reg + FILL_W'(1);
                end
            end
            S_AVG:
            begin
                avg_next = '0;
            end
            S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    avg_next = div_q[RATE_W-1:0];
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {avg_reg, last_rate_reg};
                    m_tuser_next  = stored_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= WINDOW_RST;
            min_rate_reg <= MIN_RATE_RST;
            max_rate_reg <= MAX_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW:   window_reg   <= cfg_wdata;
                CFG_MIN_RATE: min_rate_reg <= cfg_wdata[RATE_W-1:0];
                CFG_MAX_RATE: max_rate_reg <= cfg_wdata[RATE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_beat_reg <= '0;
            last_rate_reg <= '0;
            write_pos_reg <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_beat_reg <= prev_beat_next;
            last_rate_reg <= last_rate_next;
            write_pos_reg <= write_pos_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg    <= time_next;
        cutoff_reg  <= cutoff_next;
        rd_idx_reg  <= rd_idx_next;
        sum_reg     <= sum_next;
        stored_reg  <= stored_next;
        avg_reg     <= avg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_IMPLIES(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_W'(RING_DEPTH), "fill over depth")
    `ASSERT_IMPLIES(a_walk_bound, clk, rst_n, state_reg == S_WALK, cnt_reg < fill_reg, "walk overrun")
    `ASSERT_IMPLIES(a_div_owner, clk, rst_n, div_done, state_reg == S_RATE || state_reg == S_AVG_WAIT, "stray div done")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, !s_tready, "ready while busy")

endmodule

`default_nettype wire

[dv/heart_rate_window_average_unit_test.sv]
// ---------------------------------------------------------------------------
// heart_rate_window_average_unit_test
// Self-checking bench for the beat-rate tracker: a directed pass over the
// band edges, interval corner cases and window extremes, then random beat
// trains under four handshake pressure phases. Every result beat is checked
// field by field against an in-bench rate and window-average predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heart_rate_window_average_unit_test;
    import hrwa_pkg::*;

    localparam int           RING_ENTRIES   = RING_DEPTH_DEF;
    localparam logic [31:0]  BPM_SCALE      = 32'd960000;  // 60 * 1000 * 16
    localparam int           SETTLE_CYCLES  = 150;
    localparam int           WATCHDOG_LIMIT = 4000;
    localparam int           REPORT_LIMIT   = 40;

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_BEAT   = 1'b1;

    typedef struct {
        logic [11:0] last_rate;
        logic [11:0] avg_rate;
        logic        stored;
    } rate_report_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;   // [31:0] time_ms
    logic [0:0]            s_tuser   = '0;   // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // [11:0] last_rate_q4, [23:12] avg_rate_q4
    logic [0:0]            m_tuser;          // [0] beat_stored

    // predictor state and register copies
    logic [31:0]  ring_ms   [RING_ENTRIES];
    logic [11:0]  ring_rate [RING_ENTRIES];
    int unsigned  wr_pos        = 0;
    int unsigned  fill          = 0;
    logic [31:0]  prev_beat_ms  = '0;
    logic [11:0]  last_rate     = '0;
    logic [15:0]  window_ms     = WINDOW_RST;
    logic [11:0]  min_rate      = MIN_RATE_RST;
    logic [11:0]  max_rate      = MAX_RATE_RST;

    rate_report_t expected_reports[$];
    int           mismatch_count = 0;
    int           stall_cycles   = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    heart_rate_window_average_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    function automatic rate_report_t predict_rate_report(input logic beat,
                                                         input logic [31:0] now);
        logic [31:0]  interval;
        logic [31:0]  rate;
        logic [31:0]  cutoff;
        logic [31:0]  sum;
        int unsigned  n;
        int unsigned  idx;
        rate_report_t rep;
        rep.stored = 1'b0;
        if (beat)
        begin
            interval     = (prev_beat_ms == 0) ? 32'd0 : now - prev_beat_ms;
            prev_beat_ms = now;
            if (interval != 0)
            begin
                rate = BPM_SCALE / interval;
                // compare at full width so rates past 12 bits fall out of band
                if (rate >= {20'd0, min_rate} && rate <= {20'd0, max_rate})
                begin
                    last_rate         = rate[11:0];
                    ring_ms[wr_pos]   = now;
                    ring_rate[wr_pos] = rate[11:0];
                    wr_pos            = (wr_pos + 1) % RING_ENTRIES;
                    if (fill < RING_ENTRIES)
                        fill++;
                    rep.stored = 1'b1;
                end
            end
        end
        cutoff = (now > {16'd0, window_ms}) ? now - {16'd0, window_ms} : 32'd0;
        sum    = '0;
        n      = 0;
        // walk newest to oldest, stop at the first entry outside the window
        for (int i = 0; i < fill; i++)
        begin
            idx = (wr_pos + RING_ENTRIES - 1 - i) % RING_ENTRIES;
            if (ring_ms[idx] < cutoff)
                break;
            sum += {20'd0, ring_rate[idx]};
            n++;
        end
        rep.last_rate = last_rate;
        rep.avg_rate  = (n > 0) ? 12'(sum / n) : 12'd0;
        return rep;
    endfunction

    task automatic check_field(input string field, input logic [11:0] want,
                               input logic [11:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // predict on every accepted input beat, check every accepted result beat
    always @(posedge clk)
    begin
        rate_report_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_reports.push_back(predict_rate_report(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result expected none, actual %h/%h", $time,
                             m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("last_rate_q4", want.last_rate, m_tdata[11:0]);
                    check_field("avg_rate_q4", want.avg_rate, m_tdata[23:12]);
                    check_field("beat_stored", {11'd0, want.stored}, {11'd0, m_tuser[0]});
                end
            end
        end
    end

    // receiver backpressure: drop tready on a random share of cycles
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic cmd, input logic [31:0] t);
        // idle the sender on a random share of cycles before raising tvalid
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= t;
        s_tuser[0] <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_WINDOW:   window_ms = value;
            CFG_MIN_RATE: min_rate  = value[11:0];
            CFG_MAX_RATE: max_rate  = value[11:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed_cases();
        // reset settings: window 10000 ms, band 480..3520
        send_sample(CMD_REPORT, 32'd0);            // empty ring
        send_sample(CMD_BEAT,   32'd1000);         // first beat, no rate
        send_sample(CMD_BEAT,   32'd2000);         // 960
        send_sample(CMD_BEAT,   32'd2000);         // zero interval
        send_sample(CMD_BEAT,   32'd2001);         // 960000, far past 12 bits
        send_sample(CMD_BEAT,   32'd2274);         // 3516, near top of band
        send_sample(CMD_BEAT,   32'd4274);         // 480, bottom edge
        send_sample(CMD_BEAT,   32'd6275);         // 479, just below band
        send_sample(CMD_BEAT,   32'd0);            // backwards to zero, ring is newer
        send_sample(CMD_BEAT,   32'd500);          // first beat again
        send_sample(CMD_REPORT, 32'hFFFF_FFFF);    // everything outside window
        drain_reports();
        write_reg(CFG_WINDOW,   16'hFFFF);
        write_reg(CFG_MIN_RATE, 16'h0000);
        write_reg(CFG_MAX_RATE, 16'h0FFF);
        send_sample(CMD_BEAT,   32'hFFFF_FFFF);    // rate 0 accepted
        send_sample(CMD_BEAT,   32'd1000);         // wrapped interval 1001
        send_sample(CMD_BEAT,   32'd1234);         // 4102, above 4095
        send_sample(CMD_BEAT,   32'd1469);         // 4085
        send_sample(CMD_REPORT, 32'd70000);
        drain_reports();
        write_reg(CFG_WINDOW, 16'd0);
        send_sample(CMD_REPORT, 32'd1469);         // cutoff equals now
        send_sample(CMD_REPORT, 32'd1470);
        drain_reports();
        write_reg(CFG_MIN_RATE, 16'd3000);         // empty band
        write_reg(CFG_MAX_RATE, 16'd100);
        write_reg(CFG_WINDOW,   16'd1);
        send_sample(CMD_BEAT,   32'd3000);
        send_sample(CMD_BEAT,   32'd3500);
        send_sample(CMD_REPORT, 32'd3500);
        drain_reports();
    endtask

    task automatic program_random_settings();
        logic [15:0] win;
        logic [11:0] lo;
        logic [11:0] hi;
        case ($urandom_range(0, 3))
            0:       win = 16'hFFFF;
            1:       win = 16'($urandom_range(1, 3000));
            2:       win = 16'($urandom_range(3000, 65535));
            default: win = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 5))
            0:       begin lo = 12'd0; hi = 12'hFFF; end
            1:       begin lo = 12'($urandom_range(1500, 4095)); hi = 12'($urandom_range(0, 1400)); end
            2:       begin lo = 12'($urandom()); hi = 12'($urandom()); end
            3:       begin lo = MIN_RATE_RST; hi = MAX_RATE_RST; end
            default: begin lo = 12'($urandom_range(0, 900)); hi = 12'($urandom_range(1500, 4095)); end
        endcase
        write_reg(CFG_WINDOW, win);
        // upper bits of the rate writes are don't-care
        write_reg(CFG_MIN_RATE, {4'($urandom()), lo});
        write_reg(CFG_MAX_RATE, {4'($urandom()), hi});
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct,
                                       input int stall_pct);
        logic [31:0] now_ms;
        logic        cmd;
        int          pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int half = 0; half < 2; half++)
        begin
            drain_reports();
            program_random_settings();
            now_ms = $urandom();
            for (int k = 0; k < items / 2; k++)
            begin
                pick = $urandom_range(0, 99);
                cmd  = 1'($urandom());
                if (pick < 60)
                begin
                    cmd    = CMD_BEAT;
                    now_ms = now_ms + $urandom_range(273, 2000);
                end
                else if (pick < 85)
                begin
                    cmd    = CMD_REPORT;
                    now_ms = now_ms + $urandom_range(0, 300);
                end
                else if (pick < 88)
                    cmd = CMD_BEAT;                          // zero interval
                else if (pick < 91)
                begin
                    cmd    = CMD_BEAT;
                    now_ms = now_ms + $urandom_range(1, 272);
                end
                else if (pick < 93)
                    now_ms = $urandom();
                else if (pick < 95)
                    now_ms = 32'd0;
                else if (pick < 97)
                    now_ms = now_ms - $urandom_range(1, 5000);
                else
                    now_ms = now_ms + $urandom_range(2001, 200000);
                send_sample(cmd, now_ms);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic(350, 0, 0);
        test_random_traffic(350, 77, 0);
        test_random_traffic(350, 0, 77);
        test_random_traffic(350, 31, 31);
        drain_reports();
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
